// File: sv/flvd_pkg.sv
// Shared constants and types for the FLV tag deframer.
`timescale 1ns / 1ps

package flvd_pkg;

    // Parser phase codes.
    localparam logic [2:0] PH_FILE_HDR = 3'd0;
    localparam logic [2:0] PH_FILE_PTS = 3'd1;
    localparam logic [2:0] PH_TAG_HDR  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD  = 3'd3;
    localparam logic [2:0] PH_TAG_PTS  = 3'd4;

    // Section lengths in bytes, sized to compare against an incremented count.
    localparam logic [24:0] FILE_HDR_LEN = 25'd9;
    localparam logic [24:0] PTS_LEN      = 25'd4;
    localparam logic [24:0] TAG_HDR_LEN  = 25'd11;

    // File signature bytes.
    localparam logic [7:0] SIG_F = 8'h46;
    localparam logic [7:0] SIG_L = 8'h4C;
    localparam logic [7:0] SIG_V = 8'h56;

    // Tag header byte positions that carry fields.
    localparam logic [23:0] HDR_TYPE    = 24'd0;
    localparam logic [23:0] HDR_SIZE_HI = 24'd1;
    localparam logic [23:0] HDR_SIZE_MD = 24'd2;
    localparam logic [23:0] HDR_SIZE_LO = 24'd3;
    localparam logic [23:0] HDR_TIME_HI = 24'd4;
    localparam logic [23:0] HDR_TIME_MD = 24'd5;
    localparam logic [23:0] HDR_TIME_LO = 24'd6;
    localparam logic [23:0] HDR_TIME_EX = 24'd7;

    // One result item.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [4:0]  tag_type;
        logic [23:0] tag_size;
        logic [31:0] tag_timestamp;
        logic        last;
        logic        signature_bad;
    } result_t;

endpackage

// File: sv/flv_tag_deframer.sv
// Top level of the streaming FLV tag deframer.
`timescale 1ns / 1ps

// Streaming FLV tag deframer. One stream byte is taken per input request
// and the block accepts a byte in every cycle in which the skid register
// is empty: the parser decides each byte in the cycle it is accepted, so
// the rate is one byte per clock while input is not held off. A byte with
// start_of_stream set restarts parsing and clears the sticky signature_bad
// flag. The 9-byte file header is checked for the "FLV" signature, and
// then the 4-byte size field that follows it is dropped. For each tag, the
// 11 header bytes load the type, size and timestamp and produce no output.
// Each payload byte leaves as an output request with payload_valid set, and
// the fourth byte of the trailing size field leaves as a done request with
// last set and payload_byte zero. Every output request carries the current
// tag's type, size and timestamp. Results pass through an output register
// backed by a one-entry skid register, so a result is registered in one of
// the two before it leaves, and input is only held off while both are full.
module flv_tag_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic [4:0]  tag_type,
    output logic [23:0] tag_size,
    output logic [31:0] tag_timestamp,
    output logic        last,
    output logic        signature_bad
);
    import flvd_pkg::*;

    result_t res;
    logic    res_valid;
    logic    accept;
    logic    push;
    logic    take;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    // Input is held off only when the skid register is occupied.
    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign push     = accept && res_valid;
    assign take     = out_valid_reg && out_ready;

    flvd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (accept),
        .data_byte       (data_byte),
        .start_of_stream (start_of_stream),
        .res             (res),
        .res_valid       (res_valid)
    );

    // The output register refills from the skid register first, so ordering
    // is preserved; a new result lands in the skid only while the output stalls.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_data_reg.payload_byte;
    assign payload_valid = out_data_reg.payload_valid;
    assign tag_type      = out_data_reg.tag_type;
    assign tag_size      = out_data_reg.tag_size;
    assign tag_timestamp = out_data_reg.tag_timestamp;
    assign last          = out_data_reg.last;
    assign signature_bad = out_data_reg.signature_bad;

    // The skid register never holds a result while the output register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register occupied with empty output register");

    // Every result is either a payload byte or a done marker, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.payload_valid ^ out_data_reg.last))
        else $error("result is neither or both of payload and done");

    // A done marker carries a zero payload byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.last) |-> (out_data_reg.payload_byte == 8'd0))
        else $error("done result with nonzero payload byte");

    // A stalled output with a full skid cannot accept another result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> skid_valid_reg && out_valid_reg)
        else $error("buffered result lost under stall");

endmodule

// File: sv/flvd_parser.sv
// Byte-wise FLV parsing state machine with its state registers.
`timescale 1ns / 1ps

module flvd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       data_byte,
    input  logic             start_of_stream,
    output flvd_pkg::result_t res,
    output logic             res_valid
);
    import flvd_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [23:0] count_reg, count_next;
    logic [4:0]  type_reg, type_next;
    logic [23:0] size_reg, size_next;
    logic [31:0] time_reg, time_next;
    logic        bad_reg, bad_next;

    logic [2:0]  phase_eff;
    logic [23:0] count_eff;
    logic [4:0]  type_eff;
    logic [23:0] size_eff;
    logic [31:0] time_eff;
    logic        bad_eff;
    logic [24:0] count_inc;
    logic [23:0] hdr_idx;
    logic [24:0] hdr_inc;

    // A restart request sees the reset state.
    assign phase_eff = start_of_stream ? PH_FILE_HDR : phase_reg;
    assign count_eff = start_of_stream ? 24'd0 : count_reg;
    assign type_eff  = start_of_stream ? 5'd0 : type_reg;
    assign size_eff  = start_of_stream ? 24'd0 : size_reg;
    assign time_eff  = start_of_stream ? 32'd0 : time_reg;
    assign bad_eff   = start_of_stream ? 1'b0 : bad_reg;

    assign count_inc = {1'b0, count_eff} + 25'd1;
    assign hdr_idx   = (phase_eff == PH_TAG_HDR) ? count_eff : 24'd0;
    assign hdr_inc   = {1'b0, hdr_idx} + 25'd1;

    always_comb
    begin
        phase_next = phase_eff;
        count_next = count_eff;
        type_next  = type_eff;
        size_next  = size_eff;
        time_next  = time_eff;
        bad_next   = bad_eff;

        res_valid         = 1'b0;
        res.payload_byte  = 8'd0;
        res.payload_valid = 1'b0;
        res.tag_type      = type_eff;
        res.tag_size      = size_eff;
        res.tag_timestamp = time_eff;
        res.last          = 1'b0;
        res.signature_bad = bad_eff;

        unique case (phase_eff)
            PH_FILE_HDR:
            begin
                if ((count_eff == 24'd0 && data_byte != SIG_F) ||
                    (count_eff == 24'd1 && data_byte != SIG_L) ||
                    (count_eff == 24'd2 && data_byte != SIG_V))
                begin
                    bad_next = 1'b1;
                end
                if (count_inc >= FILE_HDR_LEN)
                begin
                    count_next = 24'd0;
                    phase_next = PH_FILE_PTS;
                end
                else
                begin
                    count_next = count_inc[23:0];
                end
            end
            PH_FILE_PTS:
            begin
                if (count_inc >= PTS_LEN)
                begin
                    count_next = 24'd0;
                    phase_next = PH_TAG_HDR;
                end
                else
                begin
                    count_next = count_inc[23:0];
                end
            end
            PH_PAYLOAD:
            begin
                res_valid         = 1'b1;
                res.payload_byte  = data_byte;
                res.payload_valid = 1'b1;
                if (count_inc >= {1'b0, size_eff})
                begin
                    count_next = 24'd0;
                    phase_next = PH_TAG_PTS;
                end
                else
                begin
                    count_next = count_inc[23:0];
                end
            end
            PH_TAG_PTS:
            begin
                if (count_inc >= PTS_LEN)
                begin
                    count_next = 24'd0;
                    phase_next = PH_TAG_HDR;
                    res_valid  = 1'b1;
                    res.last   = 1'b1;
                end
                else
                begin
                    count_next = count_inc[23:0];
                end
            end
            default:
            begin
                // Tag header; unused phase codes fall in here as header byte zero.
                case (hdr_idx)
                    HDR_TYPE:    type_next = data_byte[4:0];
                    HDR_SIZE_HI: size_next = {data_byte, 16'd0};
                    HDR_SIZE_MD: size_next = {size_eff[23:16], data_byte, size_eff[7:0]};
                    HDR_SIZE_LO: size_next = {size_eff[23:8], data_byte};
                    HDR_TIME_HI: time_next = {8'd0, data_byte, 16'd0};
                    HDR_TIME_MD: time_next = {time_eff[31:16], data_byte, time_eff[7:0]};
                    HDR_TIME_LO: time_next = {8'd0, time_eff[23:8], data_byte};
                    HDR_TIME_EX: time_next = {data_byte, time_eff[23:0]};
                    default:     ;
                endcase
                if (hdr_inc >= TAG_HDR_LEN)
                begin
                    count_next = 24'd0;
                    phase_next = (size_next == 24'd0) ? PH_TAG_PTS : PH_PAYLOAD;
                end
                else
                begin
                    count_next = hdr_inc[23:0];
                    phase_next = PH_TAG_HDR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FILE_HDR;
            count_reg <= 24'd0;
            type_reg  <= 5'd0;
            size_reg  <= 24'd0;
            time_reg  <= 32'd0;
            bad_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            type_reg  <= type_next;
            size_reg  <= size_next;
            time_reg  <= time_next;
            bad_reg   <= bad_next;
        end
    end

endmodule
